// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros used by the svl_checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SVL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define SVL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/svl_pkg.sv =====
// ----------------------------------------------------------------------------
// svl_pkg
// types, codes and constants of the sorted value list
// ----------------------------------------------------------------------------
package svl_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [2:0] ACT_INS_DUP  = 3'd0;
    localparam logic [2:0] ACT_INS_UNIQ = 3'd1;
    localparam logic [2:0] ACT_REM_ONE  = 3'd2;
    localparam logic [2:0] ACT_REM_ALL  = 3'd3;
    localparam logic [2:0] ACT_LOOKUP   = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_DUP    = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct packed {
        logic       load;
        logic       insert;
        logic       delete;
        logic       finish;
        logic [1:0] status_code;
    } svl_cmd_t;

    typedef struct packed {
        logic       hit;
        logic       full;
        logic       removed_nz;
        logic [2:0] action;
    } svl_stat_t;

    function automatic logic [4:0] to_out5(input cnt_t x);
        logic [CNT_W+4:0] tmp;
        tmp = {5'b0, x};
        return tmp[4:0];
    endfunction

endpackage

// ===== rtl/core/sorted_value_list_core.sv =====
// ----------------------------------------------------------------------------
// sorted_value_list_core
// ascending list of signed 32-bit values with insert, remove and lookup
//
//   channel  direction  handshake             fields
//   in       sink       in_valid / in_stall   action, key_value
//   out      source     out_valid / out_stall status, entry_count, removed_count
//
// an item is captured in the idle state, then compared against every cell and
// the cells shifted in the exec state; remove-all removes one match at a time
// reset clears the count and the handshake state, the cells need no reset
// the result sits in an output register, a stalled output holds the next
// item in the compare cycle until the register frees up
// ----------------------------------------------------------------------------
module sorted_value_list_core import svl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         action,
    input  logic signed [31:0] key_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic [4:0]         entry_count,
    output logic [4:0]         removed_count
);

    svl_cmd_t  cmd;
    svl_stat_t stat;

    svl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    svl_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .action        (action),
        .key_value     (key_value),
        .status        (status),
        .entry_count   (entry_count),
        .removed_count (removed_count)
    );

endmodule

// ===== rtl/core/svl_datapath.sv =====
// ----------------------------------------------------------------------------
// svl_datapath
// value cells with per-cell compares, shift insert/delete, counters, result regs
// ----------------------------------------------------------------------------
module svl_datapath import svl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  svl_cmd_t           cmd,
    output svl_stat_t          stat,
    input  logic [2:0]         action,
    input  logic signed [31:0] key_value,
    output logic [1:0]         status,
    output logic [4:0]         entry_count,
    output logic [4:0]         removed_count
);

    logic [2:0]         action_reg;
    logic signed [31:0] key_reg;
    logic signed [31:0] store_reg [CAPACITY];
    logic signed [31:0] store_next [CAPACITY];
    cnt_t               count_reg;
    cnt_t               count_next;
    cnt_t               removed_reg;
    cnt_t               removed_next;
    logic [1:0]         status_reg;
    logic [4:0]         entry_count_reg;
    logic [4:0]         removed_count_reg;
    logic [CAPACITY-1:0] lt;
    logic [CAPACITY-1:0] eq;

    // per-cell compare against the key
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            lt[i] = (cnt_t'(i) < count_reg) && (store_reg[i] < key_reg);
            eq[i] = (cnt_t'(i) < count_reg) && (store_reg[i] == key_reg);
        end
    end

    // insert opens a slot at the lower bound, delete closes the first match
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            store_next[i] = store_reg[i];
            if (cmd.insert && !lt[i])
            begin
                if (i == 0)
                    store_next[i] = key_reg;
                else if (lt[i-1])
                    store_next[i] = key_reg;
                else
                    store_next[i] = store_reg[i-1];
            end
            else if (cmd.delete && !lt[i] && (i < CAPACITY - 1))
            begin
                store_next[i] = store_reg[i+1];
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.insert)
            count_next = count_reg + cnt_t'(1);
        else if (cmd.delete)
            count_next = count_reg - cnt_t'(1);
    end

    always_comb
    begin
        removed_next = removed_reg;
        if (cmd.load)
            removed_next = '0;
        else if (cmd.delete)
            removed_next = removed_reg + cnt_t'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= action;
            key_reg    <= key_value;
        end
        for (int i = 0; i < CAPACITY; i++)
            store_reg[i] <= store_next[i];
        if (cmd.finish)
        begin
            status_reg        <= cmd.status_code;
            entry_count_reg   <= to_out5(count_next);
            removed_count_reg <= to_out5(removed_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            removed_reg <= '0;
        end
        else
        begin
            count_reg   <= count_next;
            removed_reg <= removed_next;
        end
    end

    assign stat.hit        = |eq;
    assign stat.full       = count_reg >= cnt_t'(CAPACITY);
    assign stat.removed_nz = removed_reg != '0;
    assign stat.action     = action_reg;

    assign status        = status_reg;
    assign entry_count   = entry_count_reg;
    assign removed_count = removed_count_reg;

endmodule

// ===== rtl/core/svl_ctrl.sv =====
// ----------------------------------------------------------------------------
// svl_ctrl
// sequencer: accepts an item, runs the action, hands off the result
// ----------------------------------------------------------------------------
module svl_ctrl import svl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    input  svl_stat_t stat,
    output svl_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign in_stall = state_reg != S_IDLE;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next       = state_reg;
        cmd              = '0;
        cmd.status_code  = ST_ABSENT;
        cmd.load         = in_valid && (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                unique case (stat.action)
                    ACT_INS_DUP:
                    begin
                        if (out_free)
                        begin
                            cmd.finish      = 1'b1;
                            cmd.insert      = !stat.full;
                            cmd.status_code = stat.full ? ST_FULL : ST_OK;
                        end
                    end
                    ACT_INS_UNIQ:
                    begin
                        if (out_free)
                        begin
                            cmd.finish = 1'b1;
                            if (stat.hit)
                                cmd.status_code = ST_DUP;
                            else if (stat.full)
                                cmd.status_code = ST_FULL;
                            else
                            begin
                                cmd.insert      = 1'b1;
                                cmd.status_code = ST_OK;
                            end
                        end
                    end
                    ACT_REM_ONE:
                    begin
                        if (out_free)
                        begin
                            cmd.finish      = 1'b1;
                            cmd.delete      = stat.hit;
                            cmd.status_code = stat.hit ? ST_OK : ST_ABSENT;
                        end
                    end
                    ACT_REM_ALL:
                    begin
                        // one match removed per cycle until none is left
                        if (stat.hit)
                            cmd.delete = 1'b1;
                        else if (out_free)
                        begin
                            cmd.finish      = 1'b1;
                            cmd.status_code = stat.removed_nz ? ST_OK : ST_ABSENT;
                        end
                    end
                    ACT_LOOKUP:
                    begin
                        if (out_free)
                        begin
                            cmd.finish      = 1'b1;
                            cmd.status_code = stat.hit ? ST_OK : ST_ABSENT;
                        end
                    end
                    default:
                    begin
                        if (out_free)
                        begin
                            cmd.finish      = 1'b1;
                            cmd.status_code = ST_ABSENT;
                        end
                    end
                endcase
                if (cmd.finish)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/core/svl_checker.sv =====
// ----------------------------------------------------------------------------
// svl_checker
// port-level checks of the sorted value list, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module svl_checker import svl_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic [2:0]         action,
    input logic signed [31:0] key_value,
    input logic               out_valid,
    input logic               out_stall,
    input logic [1:0]         status,
    input logic [4:0]         entry_count,
    input logic [4:0]         removed_count
);

    logic [4:0] cap_out;
    assign cap_out = to_out5(cnt_t'(CAPACITY));

    // stalled result holds
    `SVL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(status) && $stable(entry_count) && $stable(removed_count))
    // one item in flight: busy right after a transfer in
    `SVL_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_valid && !in_stall, in_stall)
    // nothing removed unless the status is ok
    `SVL_ASSERT_IMPL(a_removed_ok, clk, rst_n, out_valid && (status != ST_OK), removed_count == 5'd0)
    // a full refusal reports a full store
    `SVL_ASSERT_IMPL(a_full_count, clk, rst_n, out_valid && (status == ST_FULL), entry_count == cap_out)

endmodule

bind sorted_value_list_core svl_checker u_svl_checker (.*);

// ===== sim/sorted_value_list_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_value_list_checker
// watches both channels of the sorted value list, keeps its own sorted copy
// of the held values, works out the result of every accepted input transfer
// and compares each output transfer field by field with the oldest one due
// ----------------------------------------------------------------------------
module sorted_value_list_checker import svl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [2:0]         action,
    input  logic signed [31:0] key_value,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [1:0]         status,
    input  logic [4:0]         entry_count,
    input  logic [4:0]         removed_count,
    output int                 mismatch_count,
    output int                 pending_count
);

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] count;
        logic [4:0] removed;
    } list_result_t;

    logic signed [31:0] held_values[$];
    list_result_t       due_results[$];
    int                 fail_total;

    function automatic list_result_t apply_list_op(input logic [2:0] act,
                                                   input logic signed [31:0] key);
        list_result_t res;
        int           pos;
        int           removed;
        bit           present;
        pos = 0;
        while (pos < held_values.size() && held_values[pos] < key)
            pos++;
        present = (pos < held_values.size()) && (held_values[pos] == key);
        removed = 0;
        res.status = ST_ABSENT;
        case (act)
            ACT_INS_DUP:
            begin
                if (held_values.size() >= CAPACITY)
                    res.status = ST_FULL;
                else
                begin
                    held_values.insert(pos, key);
                    res.status = ST_OK;
                end
            end
            ACT_INS_UNIQ:
            begin
                if (present)
                    res.status = ST_DUP;
                else if (held_values.size() >= CAPACITY)
                    res.status = ST_FULL;
                else
                begin
                    held_values.insert(pos, key);
                    res.status = ST_OK;
                end
            end
            ACT_REM_ONE:
            begin
                if (present)
                begin
                    held_values.delete(pos);
                    removed = 1;
                    res.status = ST_OK;
                end
            end
            ACT_REM_ALL:
            begin
                while (pos < held_values.size() && held_values[pos] == key)
                begin
                    held_values.delete(pos);
                    removed++;
                end
                if (removed > 0)
                    res.status = ST_OK;
            end
            ACT_LOOKUP:
            begin
                if (present)
                    res.status = ST_OK;
            end
            default:
            begin
            end
        endcase
        res.count   = 5'(held_values.size());
        res.removed = 5'(removed);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        list_result_t got;
        list_result_t want;
        if (!rst_n)
        begin
            held_values.delete();
            due_results.delete();
            fail_total     = 0;
            mismatch_count <= 0;
            pending_count  <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got.status  = status;
                got.count   = entry_count;
                got.removed = removed_count;
                if (due_results.size() == 0)
                begin
                    $display("%0t result transfer with none due: status %0d count %0d removed %0d",
                             $time, got.status, got.count, got.removed);
                    fail_total++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (got.status !== want.status)
                    begin
                        $display("%0t status: expected %0d, got %0d",
                                 $time, want.status, got.status);
                        fail_total++;
                    end
                    if (got.count !== want.count)
                    begin
                        $display("%0t entry_count: expected %0d, got %0d",
                                 $time, want.count, got.count);
                        fail_total++;
                    end
                    if (got.removed !== want.removed)
                    begin
                        $display("%0t removed_count: expected %0d, got %0d",
                                 $time, want.removed, got.removed);
                        fail_total++;
                    end
                end
            end
            if (in_valid && !in_stall)
                due_results.push_back(apply_list_op(action, key_value));
            mismatch_count <= fail_total;
            pending_count  <= due_results.size();
        end
    end

endmodule

// ===== sim/sorted_value_list_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_value_list_core_test
// drives the sorted value list with a directed opening (empty list, extreme
// values, duplicates, a full list, bulk removal, unused actions) and then
// random transfers that alternate between filling and draining the list;
// both sides idle at random and the output is held off for long stretches
// ----------------------------------------------------------------------------
module sorted_value_list_core_test import svl_pkg::*;;

    localparam logic [2:0] ACT_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] ACT_MID_UNUSED   = 3'd6;
    localparam logic [2:0] ACT_LAST_UNUSED  = 3'd7;
    localparam int         RANDOM_ITEMS     = 1320;
    localparam int         IDLE_LIMIT       = 1000;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               in_valid      = 1'b0;
    logic               in_stall;
    logic [2:0]         action        = ACT_INS_DUP;
    logic signed [31:0] key_value     = '0;
    logic               out_valid;
    logic               out_stall     = 1'b0;
    logic [1:0]         status;
    logic [4:0]         entry_count;
    logic [4:0]         removed_count;
    int                 mismatch_count;
    int                 pending_count;
    bit                 tx_idle       = 1'b1;
    bit                 rx_idle       = 1'b1;
    int                 quiet_cycles  = 0;

    sorted_value_list_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .key_value     (key_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .entry_count   (entry_count),
        .removed_count (removed_count)
    );

    sorted_value_list_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .key_value      (key_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .entry_count    (entry_count),
        .removed_count  (removed_count),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("FAIL sorted_value_list_core");
                $finish;
            end
        end
    end

    task automatic send_transfer(input logic [2:0] act, input logic signed [31:0] key);
        int gap;
        gap = tx_idle ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        action    <= act;
        key_value <= key;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    function automatic logic signed [31:0] pick_key();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:
            begin
                case ($urandom_range(0, 3))
                    0:       return 32'sh8000_0000;
                    1:       return 32'sh7fff_ffff;
                    2:       return -32'sd1;
                    default: return 32'sd0;
                endcase
            end
            default: return $signed($urandom_range(0, 12)) - 32'sd6;
        endcase
    endfunction

    // output side: random hold-off per result, two long holds to back up the input
    initial
    begin
        int hold;
        int taken;
        taken = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (taken % 100 == 0)
                rx_idle = ($urandom_range(0, 3) != 0);
            if (taken == 150 || taken == 800)
                hold = 120;
            else
                hold = rx_idle ? $urandom_range(0, 11) : 0;
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!out_valid);
            taken++;
        end
    end

    initial
    begin
        int                 r;
        int                 ins_dup_end;
        int                 ins_uniq_end;
        int                 rem_one_end;
        bit                 fill_phase;
        logic [2:0]         act;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // empty list and unused actions
        send_transfer(ACT_LOOKUP, 32'sd0);
        send_transfer(ACT_REM_ONE, 32'sd5);
        send_transfer(ACT_REM_ALL, 32'sd5);
        send_transfer(ACT_FIRST_UNUSED, $urandom);
        send_transfer(ACT_MID_UNUSED, 32'sh7fff_ffff);
        send_transfer(ACT_LAST_UNUSED, 32'sh8000_0000);
        // extremes and duplicates
        send_transfer(ACT_INS_DUP, 32'sh8000_0000);
        send_transfer(ACT_INS_UNIQ, 32'sh7fff_ffff);
        send_transfer(ACT_INS_UNIQ, 32'sh7fff_ffff);
        send_transfer(ACT_INS_DUP, -32'sd1);
        send_transfer(ACT_LOOKUP, 32'sh8000_0000);
        // fill the list with copies of one value
        repeat (CAPACITY - 3) send_transfer(ACT_INS_DUP, 32'sd7);
        send_transfer(ACT_INS_DUP, 32'sd1);
        send_transfer(ACT_INS_UNIQ, 32'sd1);
        send_transfer(ACT_INS_UNIQ, 32'sd7);
        send_transfer(ACT_REM_ALL, 32'sd7);
        send_transfer(ACT_REM_ONE, 32'sh8000_0000);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 150 == 0)
                tx_idle = ($urandom_range(0, 3) != 0);
            fill_phase   = ((i / 120) % 2) == 0;
            ins_dup_end  = fill_phase ? 57 : 37;
            ins_uniq_end = fill_phase ? 77 : 47;
            rem_one_end  = fill_phase ? 91 : 77;
            r = $urandom_range(0, 99);
            if (r < 4)
                act = 3'($urandom_range(ACT_FIRST_UNUSED, ACT_LAST_UNUSED));
            else if (r < 17)
                act = ACT_LOOKUP;
            else if (r < ins_dup_end)
                act = ACT_INS_DUP;
            else if (r < ins_uniq_end)
                act = ACT_INS_UNIQ;
            else if (r < rem_one_end)
                act = ACT_REM_ONE;
            else
                act = ACT_REM_ALL;
            send_transfer(act, pick_key());
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS sorted_value_list_core");
        else
            $display("FAIL sorted_value_list_core");
        $finish;
    end

endmodule
